>>> rtl/assert_macros.svh
// assertion macros for the checker module
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on i_clk, off while i_rst_n is low
`define RFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked on i_clk, checked during reset too
`define RFC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/rfc_pkg.sv
// types and constants for the rpc frame checker
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int HDR_BYTES  = 16;
    localparam int COUNT_W    = 34;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [31:0] SUM_MULT = 32'd131;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_VERSION = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_MAGIC    = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_SIZE_MISMATCH = 3'd4,
        ST_BAD_CHECKSUM = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_buffer;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  msg_type;
        logic [31:0] sequence_res;
        logic [31:0] payload_length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

>>> rtl/rpc_frame_checker_core.sv
// Frame checker for a received byte stream. One input transaction per clock cycle is taken
// while o_in_stall is low. Each transaction is registered in r_item, then processed against the
// header and checksum state (checksum step: one multiply by 131 and add) once the queue has room,
// and its results go to a four-entry queue. A transaction that carries both a forwarded payload
// byte and the frame status yields two results, payload first, that leave the queue in that order;
// the input stalls only while the queue has fewer than two free entries. No clearing pass after
// reset. Registers: expected_magic at byte address 0, expected_version at byte address 4.
// depends on rfc_pkg, rfc_frame_logic, rfc_result_fifo
`timescale 1ns / 1ps

module rpc_frame_checker_core import rfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_buffer,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_sequence_res,
    output logic [31:0] o_payload_length,
    output logic        o_last
);

    logic [15:0] r_expected_magic;
    logic [7:0]  r_expected_version;
    logic        cfg_wr;

    logic        r_in_valid, n_in_valid;
    t_item       r_item;
    logic        in_accept;
    logic        go;
    logic        room;
    t_push       push;
    t_result     result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_MAGIC:   prdata = 32'(r_expected_magic);
            REG_VERSION: prdata = 32'(r_expected_version);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic   <= '0;
            r_expected_version <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MAGIC:   r_expected_magic   <= pwdata[15:0];
                REG_VERSION: r_expected_version <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    assign go         = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.data_byte     <= i_data_byte;
            r_item.has_byte      <= i_has_byte;
            r_item.end_of_buffer <= i_end_of_buffer;
        end
    end

    rfc_frame_logic u_frame (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_go               (go),
        .i_item             (r_item),
        .i_expected_magic   (r_expected_magic),
        .i_expected_version (r_expected_version),
        .o_push             (push)
    );

    rfc_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_kind           = result.kind;
    assign o_payload_byte   = result.payload_byte;
    assign o_status         = result.status;
    assign o_msg_type       = result.msg_type;
    assign o_sequence_res   = result.sequence_res;
    assign o_payload_length = result.payload_length;
    assign o_last           = result.last;

endmodule

>>> rtl/rfc_frame_logic.sv
// per-byte frame processing: header capture, byte counter, checksum and status
// depends on rfc_pkg
`timescale 1ns / 1ps

module rfc_frame_logic import rfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_item       i_item,
    input  logic [15:0] i_expected_magic,
    input  logic [7:0]  i_expected_version,
    output t_push       o_push
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_sum, n_sum;
    logic [7:0]         r_hdr [HDR_BYTES];

    logic               has;
    logic               ending;
    logic               in_hdr;
    logic [3:0]         idx_low;
    logic               hdr_wr;

    always_comb begin
        logic [COUNT_W-1:0] count_inc;
        logic [COUNT_W-1:0] cnt_e;
        logic [31:0]        sum_e;
        logic [15:0]        magic;
        logic [31:0]        seq;
        logic [31:0]        size;
        logic [31:0]        checksum;
        logic [31:0]        seed;
        logic [7:0]         hdr15;
        logic               fwd;
        t_result            pay_res;
        t_result            st_res;
        t_status            st;

        has     = i_go && i_item.has_byte;
        ending  = i_go && i_item.end_of_buffer;
        in_hdr  = (r_count[COUNT_W-1:4] == '0);
        idx_low = r_count[3:0];
        hdr_wr  = has && in_hdr;

        magic = {r_hdr[1], r_hdr[0]};
        seq   = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};
        size  = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
        hdr15 = (hdr_wr && idx_low == 4'hF) ? i_item.data_byte : r_hdr[15];
        checksum = {hdr15, r_hdr[14], r_hdr[13], r_hdr[12]};
        seed = 32'(magic) + 32'(r_hdr[2]) + 32'(r_hdr[3]) + seq + size;

        count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

        sum_e = r_sum;
        fwd   = 1'b0;
        if (has) begin
            if (in_hdr) begin
                if (idx_low == 4'hF) begin
                    sum_e = seed;
                end
            end else begin
                sum_e = 32'(r_sum * SUM_MULT) + 32'(i_item.data_byte);
                fwd   = (r_count - COUNT_W'(HDR_BYTES)) < {2'b00, size};
            end
        end
        cnt_e = has ? count_inc : r_count;

        if (cnt_e < COUNT_W'(HDR_BYTES)) begin
            st = ST_TOO_SHORT;
        end else if (magic != i_expected_magic) begin
            st = ST_BAD_MAGIC;
        end else if (r_hdr[2] != i_expected_version) begin
            st = ST_BAD_VERSION;
        end else if (cnt_e != COUNT_W'(HDR_BYTES) + {2'b00, size}) begin
            st = ST_SIZE_MISMATCH;
        end else if (sum_e != checksum) begin
            st = ST_BAD_CHECKSUM;
        end else begin
            st = ST_OK;
        end

        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = i_item.data_byte;

        st_res        = '0;
        st_res.kind   = KIND_STATUS;
        st_res.status = st;
        st_res.last   = 1'b1;
        if (st != ST_TOO_SHORT) begin
            st_res.msg_type       = r_hdr[3];
            st_res.sequence_res   = seq;
            st_res.payload_length = size;
        end

        o_push.num    = 2'(fwd) + 2'(ending);
        o_push.first  = fwd ? pay_res : st_res;
        o_push.second = st_res;

        n_count = ending ? '0 : cnt_e;
        n_sum   = ending ? '0 : sum_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_wr) begin
            r_hdr[idx_low] <= i_item.data_byte;
        end
    end

endmodule

>>> rtl/rfc_result_fifo.sv
// small result queue taking up to two results per cycle, giving one per cycle unless i_stall is high
// depends on rfc_pkg
`timescale 1ns / 1ps

module rfc_result_fifo import rfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;

    assign o_valid     = (r_count != '0);
    assign o_result    = r_mem[r_rd_ptr];
    assign o_room      = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop         = o_valid && !i_stall;
    assign wr_ptr_next = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.num);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + FIFO_CNT_W'(i_push.num) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

endmodule

>>> rtl/rfc_checker.sv
// port-level checks for rpc_frame_checker_core, attached by bind
// depends on rfc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfc_checker import rfc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [2:0]  o_status,
    input logic [7:0]  o_msg_type,
    input logic [31:0] o_sequence_res,
    input logic [31:0] o_payload_length,
    input logic        o_last
);

    `RFC_ASSERT_ALWAYS(a_pready_high, pready, "pready must stay high")

    `RFC_ASSERT(a_payload_clean,
        (o_out_valid && o_kind == KIND_PAYLOAD) |->
            (!o_last && o_status == ST_OK && o_msg_type == 8'd0),
        "payload transaction carries status fields")

    `RFC_ASSERT(a_status_last,
        (o_out_valid && o_kind == KIND_STATUS) |-> (o_last && o_payload_byte == 8'd0),
        "status transaction must end the frame")

    `RFC_ASSERT(a_short_zero,
        (o_out_valid && o_kind == KIND_STATUS && o_status == ST_TOO_SHORT) |->
            (o_sequence_res == 32'd0 && o_payload_length == 32'd0),
        "short frame reports header fields")

    `RFC_ASSERT(a_out_hold,
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_payload_byte) && $stable(o_status)),
        "stalled result changed")

endmodule

bind rpc_frame_checker_core rfc_checker u_rfc_checker (.*);

>>> tb/rpc_frame_checker_core_test.sv
// testbench for rpc_frame_checker_core: drives buffers of frames, writes the apb registers
// and checks every result transaction against a predictor of the frame checks
// depends on rfc_pkg and rpc_frame_checker_core
`timescale 1ns / 1ps

module rpc_frame_checker_core_test;
    import rfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_buffer = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_msg_type;
    logic [31:0] o_sequence_res;
    logic [31:0] o_payload_length;
    logic        o_last;

    rpc_frame_checker_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_status         (o_status),
        .o_msg_type       (o_msg_type),
        .o_sequence_res   (o_sequence_res),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [15:0]        mag_setting = '0;
    logic [7:0]         ver_setting = '0;
    logic [COUNT_W-1:0] frame_count = '0;
    logic [7:0]         hdr_bytes [HDR_BYTES];
    logic [31:0]        frame_sum = '0;
    t_result            pending_frame_results [$];

    logic [7:0]  frame_bytes [$];
    int unsigned sent_items = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          tx_random = 1'b0;
    bit          rx_random = 1'b0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_gap_left = 0;

    initial begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_bytes[i] = '0;
        end
    end

    function automatic logic [31:0] hdr_word(int at);
        return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    function automatic void predict_frame_results(logic [7:0] d, logic has, logic eob);
        t_result     r;
        t_status     st;
        logic [31:0] size;
        if (has) begin
            if (frame_count < HDR_BYTES) begin
                hdr_bytes[frame_count[3:0]] = d;
                if (frame_count == HDR_BYTES - 1) begin
                    frame_sum = 32'({hdr_bytes[1], hdr_bytes[0]}) + 32'(hdr_bytes[2])
                              + 32'(hdr_bytes[3]) + hdr_word(4) + hdr_word(8);
                end
            end else begin
                frame_sum = frame_sum * SUM_MULT + 32'(d);
                if (frame_count - HDR_BYTES < COUNT_W'(hdr_word(8))) begin
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = d;
                    pending_frame_results.push_back(r);
                end
            end
            if (frame_count != COUNT_MAX) frame_count++;
        end
        if (eob) begin
            r = '0;
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            if (frame_count < HDR_BYTES) begin
                r.status = ST_TOO_SHORT;
            end else begin
                size = hdr_word(8);
                if ({hdr_bytes[1], hdr_bytes[0]} != mag_setting) st = ST_BAD_MAGIC;
                else if (hdr_bytes[2] != ver_setting) st = ST_BAD_VERSION;
                else if (frame_count != COUNT_W'(HDR_BYTES) + COUNT_W'(size))
                    st = ST_SIZE_MISMATCH;
                else if (frame_sum != hdr_word(12)) st = ST_BAD_CHECKSUM;
                else st = ST_OK;
                r.status = st;
                r.msg_type = hdr_bytes[3];
                r.sequence_res = hdr_word(4);
                r.payload_length = size;
            end
            pending_frame_results.push_back(r);
            frame_count = '0;
            frame_sum = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frame_results.size() == 0) begin
                $error("result transaction with none expected: kind %0d status %0d",
                       o_kind, o_status);
                mismatches++;
            end else begin
                want = pending_frame_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("msg_type", 32'(want.msg_type), 32'(o_msg_type));
                check_field("sequence_res", want.sequence_res, o_sequence_res);
                check_field("payload_length", want.payload_length, o_payload_length);
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // receiver stalls: long hold on request, else random gaps when rx_random is set
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_random) begin
            i_out_stall <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 60) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_gap_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                       : $urandom_range(7, 40);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] d, logic has, logic eob);
        int unsigned gap;
        int unsigned pick;
        gap = 0;
        if (tx_random) begin
            pick = $urandom_range(0, 99);
            if (pick >= 65) gap = (pick < 93) ? $urandom_range(1, 3) : $urandom_range(6, 30);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= d;
        i_has_byte <= has;
        i_end_of_buffer <= eob;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_frame_results(d, has, eob);
        if (has || eob) sent_items++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_frame_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [31:0] magic_word, logic [31:0] version_word);
        write_reg(REG_MAGIC, magic_word);
        write_reg(REG_VERSION, version_word);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mag_setting = magic_word[15:0];
        ver_setting = version_word[7:0];
    endtask

    // header little-endian, checksum over seed and the body bytes built into the frame, then XORed with flip
    function automatic void build_frame(logic [15:0] magic, logic [7:0] ver, logic [7:0] mtype,
                                        logic [31:0] seq, logic [31:0] size,
                                        int unsigned body_len, logic [31:0] flip);
        logic [31:0] sum;
        logic [7:0]  body [$];
        sum = 32'(magic) + 32'(ver) + 32'(mtype) + seq + size;
        for (int unsigned i = 0; i < body_len; i++) begin
            body.push_back(8'($urandom));
            sum = sum * SUM_MULT + 32'(body[i]);
        end
        sum ^= flip;
        frame_bytes.delete();
        frame_bytes.push_back(magic[7:0]);
        frame_bytes.push_back(magic[15:8]);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(mtype);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(seq[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(size[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(sum[8*i +: 8]);
        foreach (body[i]) frame_bytes.push_back(body[i]);
    endfunction

    task automatic send_frame(bit end_joined);
        int n = frame_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (tx_random && $urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(frame_bytes[i], 1'b1, end_joined && i == n - 1);
        end
        if (!end_joined || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_random_frame();
        logic [15:0] magic;
        logic [7:0]  ver;
        logic [31:0] size;
        logic [31:0] flip;
        int unsigned plen;
        int unsigned body_len;
        int unsigned pick;
        int unsigned cut;
        magic = mag_setting;
        ver = ver_setting;
        flip = '0;
        cut = 1000;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 12);
        size = plen;
        body_len = plen;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            magic = mag_setting ^ 16'($urandom_range(1, 16'hFFFF));
            if ($urandom_range(0, 1)) ver = ver_setting ^ 8'($urandom_range(1, 255));
        end else if (pick < 15) begin
            ver = ver_setting ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1)) body_len = plen + $urandom_range(1, 4);
        end else if (pick < 22) begin
            body_len = plen + $urandom_range(1, 4);
        end else if (pick < 27) begin
            if (plen > 0) body_len = $urandom_range(0, plen - 1);
            else size = $urandom | 32'h1;
        end else if (pick < 32) begin
            size = $urandom;
            if (size == plen) size = ~size;
        end else if (pick < 39) begin
            flip = $urandom | 32'h1;
        end else if (pick < 44) begin
            cut = $urandom_range(0, 15);
        end
        build_frame(magic, ver, 8'($urandom), $urandom, size, body_len, flip);
        if (pick >= 44 && pick < 47) begin
            // random bytes with no header structure
            frame_bytes.delete();
            repeat ($urandom_range(0, 40)) frame_bytes.push_back(8'($urandom));
        end
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        send_frame($urandom_range(0, 1));
    endtask

    task automatic test_directed();
        tx_random = 1'b0;
        rx_random = 1'b0;
        // empty end marker and a one-byte buffer on reset settings
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        wait_idle();
        write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        build_frame(16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'd1, 1, 32'd0);
        send_item(8'h5A, 1'b0, 1'b0);
        // last payload byte and end in one transaction
        send_frame(1'b1);
        wait_idle();
    endtask

    task automatic test_mid_buffer_config();
        logic [15:0] new_magic;
        logic [7:0]  new_ver;
        int          n;
        tx_random = 1'b1;
        rx_random = 1'b1;
        new_magic = 16'($urandom);
        new_ver = 8'($urandom);
        build_frame(new_magic, new_ver, 8'($urandom), $urandom, 32'd5, 5, 32'd0);
        n = frame_bytes.size();
        for (int i = 0; i < 9; i++) send_item(frame_bytes[i], 1'b1, 1'b0);
        wait_idle();
        write_settings(32'(new_magic), 32'(new_ver));
        for (int i = 9; i < n; i++) send_item(frame_bytes[i], 1'b1, i == n - 1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_random = 1'b0;
        rx_random = 1'b0;
        rx_hold_req = 300;
        repeat (3) begin
            build_frame(mag_setting, ver_setting, 8'($urandom), $urandom, 32'd40, 40, 32'd0);
            send_frame(1'b1);
        end
        // sender waits for the full drain
        wait_idle();
    endtask

    task automatic test_random_frames(int unsigned goal);
        int unsigned phase;
        int unsigned first;
        phase = 0;
        first = sent_items;
        while (sent_items - first < goal) begin
            wait_idle();
            case (phase % 4)
                0: write_settings(32'h0, 32'h0);
                1: write_settings(32'h0000_FFFF, 32'h0000_00FF);
                default: write_settings($urandom, $urandom);
            endcase
            tx_random = (phase % 3 != 2);
            rx_random = (phase % 5 != 3);
            repeat (6) send_random_frame();
            phase++;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_mid_buffer_config();
        test_backpressure();
        test_random_frames(1430);
        wait_idle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
